// ----- hdl/fprle_pkg.sv -----
// ----------------------------------------------------------------------------
// fprle_pkg
// Shared types, constants and helpers for the foreground palette run-length
// encoder.
// ----------------------------------------------------------------------------
package fprle_pkg;

   localparam int CHAN_W      = 8;
   localparam int CODE_W      = 12;
   localparam int LEN_W       = 20;
   localparam int LEVEL_W     = 3;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

   localparam logic [CODE_W-1:0] TRANSPARENT_CODE = 12'hfff;
   localparam logic [CHAN_W-1:0] CHANNEL_MAX      = 8'hff;
   localparam logic [CHAN_W-1:0] LEVEL_STEP       = 8'd51;
   localparam logic [CODE_W-1:0] LEVELS           = 12'd6;
   localparam logic [LEN_W-1:0]  LINE_WIDTH_RESET = 20'd2550;

   typedef enum logic {
      REG_LINE_WIDTH = 1'b0,
      REG_MASK_ONLY  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic              bg_hit;
      logic              fg_hit;
      logic              sop;
   } pixel_type;

   typedef struct packed {
      logic [CODE_W-1:0] run_color;
      logic [LEN_W-1:0]  run_length;
      logic              end_of_row;
      logic              last_for_pixel;
      logic              background_seen;
      logic              foreground_seen;
   } rsp_word_type;

   typedef struct packed {
      logic [LEN_W-1:0] line_width;
      logic             mask_only;
   } cfg_type;

   // Channel value divided by 51, by a compare chain
   function automatic logic [LEVEL_W-1:0] level_of(input logic [CHAN_W-1:0] c);
      logic [LEVEL_W-1:0] q;
      q = '0;
      if (c >= LEVEL_STEP)                  q = 3'd1;
      if (c >= 8'(2 * LEVEL_STEP))          q = 3'd2;
      if (c >= 8'(3 * LEVEL_STEP))          q = 3'd3;
      if (c >= 8'(4 * LEVEL_STEP))          q = 3'd4;
      if (c >= 8'(5 * LEVEL_STEP))          q = 3'd5;
      return q;
   endfunction

endpackage

// ----- hdl/fprle_req_if.sv -----
// ----------------------------------------------------------------------------
// fprle_req_if
// Pixel word channel: full and muted render pixels plus page start.
// ----------------------------------------------------------------------------
interface fprle_req_if;
   import fprle_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] full_red;
   logic [CHAN_W-1:0] full_green;
   logic [CHAN_W-1:0] full_blue;
   logic [CHAN_W-1:0] muted_red;
   logic [CHAN_W-1:0] muted_green;
   logic [CHAN_W-1:0] muted_blue;
   logic              start_of_page;

   modport source (
      output valid, full_red, full_green, full_blue,
             muted_red, muted_green, muted_blue, start_of_page,
      input  ready
   );

   modport sink (
      input  valid, full_red, full_green, full_blue,
             muted_red, muted_green, muted_blue, start_of_page,
      output ready
   );
endinterface

// ----- hdl/fprle_rsp_if.sv -----
// ----------------------------------------------------------------------------
// fprle_rsp_if
// Run word channel: palette color, run length, row end and page flags.
// ----------------------------------------------------------------------------
interface fprle_rsp_if;
   import fprle_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] run_color;
   logic [LEN_W-1:0]  run_length;
   logic              end_of_row;
   logic              last_for_pixel;
   logic              background_seen;
   logic              foreground_seen;

   modport source (
      output valid, run_color, run_length, end_of_row, last_for_pixel,
             background_seen, foreground_seen,
      input  ready
   );

   modport sink (
      input  valid, run_color, run_length, end_of_row, last_for_pixel,
             background_seen, foreground_seen,
      output ready
   );
endinterface

// ----- hdl/fprle_csr.sv -----
// ----------------------------------------------------------------------------
// fprle_csr
// APB-style register file: line width and mask-only mode.
// ----------------------------------------------------------------------------
module fprle_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fprle_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fprle_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fprle_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready,
   output fprle_pkg::cfg_type                cfg
);
   import fprle_pkg::*;

   logic [LEN_W-1:0] line_width_ff, line_width_in;
   logic             mask_only_ff, mask_only_in;
   logic             wr_en;
   reg_index_type    sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign sel        = reg_index_type'(csr_paddr[2]);

   always_comb begin
      line_width_in = line_width_ff;
      mask_only_in  = mask_only_ff;
      csr_prdata    = '0;
      unique case (sel)
         REG_LINE_WIDTH: begin
            csr_prdata = CSR_DATA_W'(line_width_ff);
            if (wr_en) line_width_in = csr_pwdata[LEN_W-1:0];
         end
         REG_MASK_ONLY: begin
            csr_prdata = CSR_DATA_W'(mask_only_ff);
            if (wr_en) mask_only_in = csr_pwdata[0];
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         mask_only_ff  <= 1'b0;
      end else begin
         line_width_ff <= line_width_in;
         mask_only_ff  <= mask_only_in;
      end
   end

   assign cfg.line_width = line_width_ff;
   assign cfg.mask_only  = mask_only_ff;
endmodule

// ----- hdl/fprle_classify.sv -----
// ----------------------------------------------------------------------------
// fprle_classify
// Input register: quantize the full pixel to a palette code or mark it
// transparent, and capture the flag hits.
// ----------------------------------------------------------------------------
module fprle_classify (
   input  logic                 clock,
   input  logic                 reset,
   fprle_req_if.sink            req_ch,
   input  logic                 mask_only,
   input  logic                 take,
   output logic                 pix_valid,
   output fprle_pkg::pixel_type pix
);
   import fprle_pkg::*;

   logic               valid_ff, valid_in;
   pixel_type          pix_ff, pix_in;
   logic               differ;
   logic [LEVEL_W-1:0] lr, lg, lb;
   logic [CODE_W-1:0]  palette;

   assign req_ch.ready = !valid_ff || take;

   always_comb begin
      lr      = level_of(req_ch.full_red);
      lg      = level_of(req_ch.full_green);
      lb      = level_of(req_ch.full_blue);
      palette = CODE_W'(lb) + LEVELS * (CODE_W'(lg) + LEVELS * CODE_W'(lr));
      differ  = (req_ch.full_red   != req_ch.muted_red)   ||
                (req_ch.full_green != req_ch.muted_green) ||
                (req_ch.full_blue  != req_ch.muted_blue);

      pix_in.sop    = req_ch.start_of_page;
      pix_in.bg_hit = !mask_only &&
                      ((req_ch.muted_red & req_ch.muted_green & req_ch.muted_blue)
                       != CHANNEL_MAX);
      pix_in.fg_hit = !mask_only && differ &&
                      ((req_ch.full_red | req_ch.full_green | req_ch.full_blue) != '0);
      pix_in.code   = (!mask_only && differ) ? palette : TRANSPARENT_CODE;
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_ch.valid && req_ch.ready) valid_in = 1'b1;
      else if (take)                    valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = valid_ff;
   assign pix       = pix_ff;
endmodule

// ----- hdl/fprle_runner.sv -----
// ----------------------------------------------------------------------------
// fprle_runner
// Run state and row position; emits up to two run words per pixel into a
// small result queue that drives the output channel.
// ----------------------------------------------------------------------------
module fprle_runner (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [fprle_pkg::LEN_W-1:0] line_width,
   input  logic                 pix_valid,
   input  fprle_pkg::pixel_type pix,
   output logic                 take,
   fprle_rsp_if.source          rsp_ch
);
   import fprle_pkg::*;

   logic [CODE_W-1:0]  code_ff, code_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   col_ff, col_in;
   logic               bg_ff, bg_in;
   logic               fg_ff, fg_in;

   rsp_word_type       fifo [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;

   logic [LEN_W-1:0]   width;
   logic [CODE_W-1:0]  base_code, mid_code;
   logic [LEN_W-1:0]   base_len, mid_len;
   logic [LEN_W-1:0]   base_col, col_next;
   logic               push_a, push_b, pop;
   logic               row_end;
   logic [FIFO_AW-1:0] idx_b;
   rsp_word_type       word_a, word_b, head;

   assign take  = pix_valid && (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));
   assign width = (line_width == '0) ? LEN_W'(1) : line_width;

   always_comb begin
      base_code = pix.sop ? TRANSPARENT_CODE : code_ff;
      base_len  = pix.sop ? '0 : len_ff;
      base_col  = pix.sop ? '0 : col_ff;
      bg_in     = bg_ff;
      fg_in     = fg_ff;
      if (take) begin
         bg_in = (pix.sop ? 1'b0 : bg_ff) | pix.bg_hit;
         fg_in = (pix.sop ? 1'b0 : fg_ff) | pix.fg_hit;
      end

      push_a = 1'b0;
      if (pix.code == base_code) begin
         mid_code = base_code;
         mid_len  = base_len + LEN_W'(1);
      end else begin
         push_a   = (base_len != '0);
         mid_code = pix.code;
         mid_len  = LEN_W'(1);
      end

      col_next = base_col + LEN_W'(1);
      row_end  = (col_next >= width) || (col_next == '0);
      push_b   = row_end;

      word_a.run_color       = base_code;
      word_a.run_length      = base_len;
      word_a.end_of_row      = 1'b0;
      word_a.last_for_pixel  = !push_b;
      word_a.background_seen = bg_in;
      word_a.foreground_seen = fg_in;

      word_b.run_color       = mid_code;
      word_b.run_length      = mid_len;
      word_b.end_of_row      = 1'b1;
      word_b.last_for_pixel  = 1'b1;
      word_b.background_seen = bg_in;
      word_b.foreground_seen = fg_in;

      code_in = code_ff;
      len_in  = len_ff;
      col_in  = col_ff;
      if (take) begin
         if (row_end) begin
            code_in = TRANSPARENT_CODE;
            len_in  = '0;
            col_in  = '0;
         end else begin
            code_in = mid_code;
            len_in  = mid_len;
            col_in  = col_next;
         end
      end
   end

   // Queue pointers and fill count
   always_comb begin
      pop       = (count_ff != '0) && rsp_ch.ready;
      idx_b     = push_a ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (take) begin
         wr_ptr_in = wr_ptr_ff + FIFO_AW'(push_a) + FIFO_AW'(push_b);
         count_in  = count_ff + FIFO_CW'(push_a) + FIFO_CW'(push_b);
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FIFO_AW'(1);
         count_in  = count_in - FIFO_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff   <= TRANSPARENT_CODE;
         len_ff    <= '0;
         col_ff    <= '0;
         bg_ff     <= 1'b0;
         fg_ff     <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         code_ff   <= code_in;
         len_ff    <= len_in;
         col_ff    <= col_in;
         bg_ff     <= bg_in;
         fg_ff     <= fg_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && push_a) begin
         fifo[wr_ptr_ff] <= word_a;
      end
      if (take && push_b) begin
         fifo[idx_b] <= word_b;
      end
   end

   assign head                   = fifo[rd_ptr_ff];
   assign rsp_ch.valid           = (count_ff != '0);
   assign rsp_ch.run_color       = head.run_color;
   assign rsp_ch.run_length      = head.run_length;
   assign rsp_ch.end_of_row      = head.end_of_row;
   assign rsp_ch.last_for_pixel  = head.last_for_pixel;
   assign rsp_ch.background_seen = head.background_seen;
   assign rsp_ch.foreground_seen = head.foreground_seen;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (count_ff == '0) && !rsp_ch.valid)
      else $error("result queue not empty after reset");

   a_eor_last: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.end_of_row |-> rsp_ch.last_for_pixel)
      else $error("row-end word not marked last for its pixel");

   a_take_room: assert property (@(posedge clock) disable iff (reset)
      take |=> count_ff <= FIFO_CW'(FIFO_DEPTH))
      else $error("pixel taken without room for two words");
`endif
endmodule

// ----- hdl/foreground_palette_run_length_encoder_core.sv -----
// ----------------------------------------------------------------------------
// A run word is offered once the pixel that closes it has passed the input
// register and then the result queue.
// Throughput: one pixel per cycle while the result queue has room for two words;
// a pixel that closes two runs queues two words for the single-word output port.
// Reset: synchronous, active high; clears run state, flags, queue and sets
// line width 2550, mask-only off.
// ----------------------------------------------------------------------------
// foreground_palette_run_length_encoder_core
// Top level: register file, pixel classifier and run encoder.
// ----------------------------------------------------------------------------
module foreground_palette_run_length_encoder_core (
   input  logic                              clock,
   input  logic                              reset,
   fprle_req_if.sink                         req_ch,
   fprle_rsp_if.source                       rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fprle_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fprle_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fprle_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import fprle_pkg::*;

   cfg_type   cfg;
   pixel_type pix;
   logic      pix_valid;
   logic      take;

   fprle_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fprle_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .mask_only (cfg.mask_only),
      .take      (take),
      .pix_valid (pix_valid),
      .pix       (pix)
   );

   fprle_runner u_runner (
      .clock      (clock),
      .reset      (reset),
      .line_width (cfg.line_width),
      .pix_valid  (pix_valid),
      .pix        (pix),
      .take       (take),
      .rsp_ch     (rsp_ch)
   );
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the foreground palette run-length encoder core. Pixel words go in
// with random gaps. A scoreboard predicts every run word from its own copy of
// the run state and the registers, and compares each received run word, in
// order, against that prediction. The registers are written and read back
// over the APB port while no run word is outstanding.
// ----------------------------------------------------------------------------
module tb_top;
   import fprle_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SEG_ITEMS    = 175;

   typedef struct packed {
      logic [CHAN_W-1:0] full_red;
      logic [CHAN_W-1:0] full_green;
      logic [CHAN_W-1:0] full_blue;
      logic [CHAN_W-1:0] muted_red;
      logic [CHAN_W-1:0] muted_green;
      logic [CHAN_W-1:0] muted_blue;
      logic              start_of_page;
   } pixel_word_type;

   class run_scoreboard;
      rsp_word_type      expected_runs[$];
      logic [LEN_W-1:0]  line_width;
      logic              mask_only;
      logic [CODE_W-1:0] open_code;
      logic [LEN_W-1:0]  open_length;
      logic [LEN_W-1:0]  column;
      logic              bg_flag;
      logic              fg_flag;
      int                mismatch_count;

      function new();
         line_width     = LINE_WIDTH_RESET;
         mask_only      = 1'b0;
         open_code      = TRANSPARENT_CODE;
         open_length    = '0;
         column         = '0;
         bg_flag        = 1'b0;
         fg_flag        = 1'b0;
         mismatch_count = 0;
      endfunction

      function void note_mismatch(string what);
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("mismatch: %s", what);
         end
      endfunction

      function string run_text(rsp_word_type r);
         return $sformatf("color %0d length %0d eor %0b last %0b bg %0b fg %0b",
                          r.run_color, r.run_length, r.end_of_row, r.last_for_pixel,
                          r.background_seen, r.foreground_seen);
      endfunction

      function rsp_word_type make_run(logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                                      logic eor);
         rsp_word_type r;
         r.run_color       = code;
         r.run_length      = len;
         r.end_of_row      = eor;
         r.last_for_pixel  = 1'b0;
         r.background_seen = bg_flag;
         r.foreground_seen = fg_flag;
         return r;
      endfunction

      function void predict_pixel(pixel_word_type p);
         logic [CODE_W-1:0] code;
         logic [LEN_W-1:0]  width;
         rsp_word_type      made[2];
         int                n;
         width = (line_width == '0) ? LEN_W'(1) : line_width;
         n = 0;
         if (p.start_of_page) begin
            bg_flag     = 1'b0;
            fg_flag     = 1'b0;
            column      = '0;
            open_code   = TRANSPARENT_CODE;
            open_length = '0;
         end
         if (mask_only) begin
            code = TRANSPARENT_CODE;
         end else begin
            if ((p.muted_red & p.muted_green & p.muted_blue) != CHANNEL_MAX) bg_flag = 1'b1;
            if ({p.full_red, p.full_green, p.full_blue} !=
                {p.muted_red, p.muted_green, p.muted_blue}) begin
               if (|{p.full_red, p.full_green, p.full_blue}) fg_flag = 1'b1;
               code = p.full_blue / LEVEL_STEP +
                      LEVELS * (p.full_green / LEVEL_STEP + LEVELS * (p.full_red / LEVEL_STEP));
            end else begin
               code = TRANSPARENT_CODE;
            end
         end
         if (code == open_code) begin
            open_length = open_length + 1'b1;
         end else begin
            if (open_length != '0) begin
               made[n] = make_run(open_code, open_length, 1'b0);
               n++;
            end
            open_code   = code;
            open_length = LEN_W'(1);
         end
         column = column + 1'b1;
         if (column >= width || column == '0) begin
            made[n] = make_run(open_code, open_length, 1'b1);
            n++;
            column      = '0;
            open_code   = TRANSPARENT_CODE;
            open_length = '0;
         end
         for (int i = 0; i < n; i++) begin
            if (i == n - 1) made[i].last_for_pixel = 1'b1;
            expected_runs = {expected_runs, made[i]};
         end
      endfunction

      function void check_run(rsp_word_type got);
         rsp_word_type want;
         if (expected_runs.size() == 0) begin
            note_mismatch({"unexpected run word: ", run_text(got)});
         end else begin
            want = expected_runs.pop_front();
            if (got !== want) begin
               note_mismatch({"expected ", run_text(want), " got ", run_text(got)});
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fprle_req_if req_ch ();
   fprle_rsp_if rsp_ch ();

   foreground_palette_run_length_encoder_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   run_scoreboard  runs;
   int             src_idle_pct;
   int             sink_idle_pct;
   int             stall_cycles;
   rsp_word_type   got_run;
   pixel_word_type seen_pixel;
   pixel_word_type pix;

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_pixel.full_red      = req_ch.full_red;
            seen_pixel.full_green    = req_ch.full_green;
            seen_pixel.full_blue     = req_ch.full_blue;
            seen_pixel.muted_red     = req_ch.muted_red;
            seen_pixel.muted_green   = req_ch.muted_green;
            seen_pixel.muted_blue    = req_ch.muted_blue;
            seen_pixel.start_of_page = req_ch.start_of_page;
            runs.predict_pixel(seen_pixel);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_run.run_color       = rsp_ch.run_color;
            got_run.run_length      = rsp_ch.run_length;
            got_run.end_of_row      = rsp_ch.end_of_row;
            got_run.last_for_pixel  = rsp_ch.last_for_pixel;
            got_run.background_seen = rsp_ch.background_seen;
            got_run.foreground_seen = rsp_ch.foreground_seen;
            runs.check_run(got_run);
         end
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("foreground_palette_run_length_encoder_core test failed");
      $finish;
   end

   task automatic send_pixel(input pixel_word_type p);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.full_red      <= p.full_red;
      req_ch.full_green    <= p.full_green;
      req_ch.full_blue     <= p.full_blue;
      req_ch.muted_red     <= p.muted_red;
      req_ch.muted_green   <= p.muted_green;
      req_ch.muted_blue    <= p.muted_blue;
      req_ch.start_of_page <= p.start_of_page;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the input low until every run word has come, then let the pipe empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (runs.expected_runs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      readback = (idx == REG_LINE_WIDTH) ? CSR_DATA_W'(value[LEN_W-1:0])
                                         : CSR_DATA_W'(value[0]);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_LINE_WIDTH) begin
         runs.line_width = value[LEN_W-1:0];
      end else begin
         runs.mask_only = value[0];
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== readback) begin
         runs.note_mismatch($sformatf("register %0d read %h, expected %h",
                                      idx, csr_prdata, readback));
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [LEN_W-1:0] width, input logic mask);
      settle();
      write_csr(REG_LINE_WIDTH, CSR_DATA_W'(width));
      write_csr(REG_MASK_ONLY, CSR_DATA_W'(mask));
   endtask

   function automatic pixel_word_type pixel(input logic [23:0] full, input logic [23:0] muted,
                                            input logic sop);
      pixel_word_type p;
      {p.full_red, p.full_green, p.full_blue}    = full;
      {p.muted_red, p.muted_green, p.muted_blue} = muted;
      p.start_of_page = sop;
      return p;
   endfunction

   function automatic pixel_word_type next_pixel(input pixel_word_type prev);
      pixel_word_type p;
      int unsigned    pick;
      pick = $urandom_range(99);
      {p.full_red, p.full_green, p.full_blue}    = 24'($urandom);
      {p.muted_red, p.muted_green, p.muted_blue} = 24'($urandom);
      if (pick < 30) begin
         p = prev;
      end else if (pick < 50) begin
         {p.muted_red, p.muted_green, p.muted_blue} = {p.full_red, p.full_green, p.full_blue};
      end else if (pick < 65) begin
         p.full_red   = 8'($urandom_range(5) * 51);
         p.full_green = 8'($urandom_range(5) * 51);
         p.full_blue  = 8'($urandom_range(5) * 51);
         {p.muted_red, p.muted_green, p.muted_blue} = 24'hffffff;
      end else if (pick < 75) begin
         {p.muted_red, p.muted_green, p.muted_blue} =
            {p.full_red, p.full_green, p.full_blue} ^ (24'h1 << $urandom_range(23));
      end else if (pick < 82) begin
         {p.full_red, p.full_green, p.full_blue} = 24'h000000;
      end
      p.start_of_page = ($urandom_range(99) < 3);
      return p;
   endfunction

   initial begin
      runs           = new();
      src_idle_pct   = 0;
      sink_idle_pct  = 0;
      stall_cycles   = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.full_red      <= '0;
      req_ch.full_green    <= '0;
      req_ch.full_blue     <= '0;
      req_ch.muted_red     <= '0;
      req_ch.muted_green   <= '0;
      req_ch.muted_blue    <= '0;
      req_ch.start_of_page <= 1'b0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one code change in a long row
      send_pixel(pixel(24'hffffff, 24'hffffff, 1'b1));
      send_pixel(pixel(24'h000000, 24'hffffff, 1'b0));

      configure(LEN_W'(4), 1'b0);
      send_pixel(pixel(24'hffffff, 24'hffffff, 1'b1));
      send_pixel(pixel(24'h000000, 24'hffffff, 1'b0));
      send_pixel(pixel(24'hffffff, 24'hfeffff, 1'b0));
      send_pixel(pixel(24'hffffff, 24'hfffeff, 1'b0));
      send_pixel(pixel(24'h323365, 24'hfffffe, 1'b1));
      send_pixel(pixel(24'h66ccfe, 24'h66ccfe, 1'b0));
      send_pixel(pixel(24'h999833, 24'h000000, 1'b0));
      send_pixel(pixel(24'h999833, 24'h000000, 1'b0));
      // drop the open run on a page start mid-row
      send_pixel(pixel(24'h102030, 24'h000000, 1'b0));
      send_pixel(pixel(24'h102030, 24'h000000, 1'b1));
      send_pixel(pixel(24'h102030, 24'h000000, 1'b0));
      // shrink the width below the current column
      configure(LEN_W'(1), 1'b0);
      send_pixel(pixel(24'h102030, 24'h000000, 1'b0));
      configure('0, 1'b0);
      send_pixel(pixel(24'hff0000, 24'h00ff00, 1'b0));
      send_pixel(pixel(24'h0000ff, 24'h0000ff, 1'b0));
      send_pixel(pixel(24'h00ff00, 24'hffffff, 1'b0));
      // mask mid-page keeps the flags, a page start clears them
      configure(LEN_W'(3), 1'b1);
      send_pixel(pixel(24'hff00ff, 24'h000000, 1'b0));
      send_pixel(pixel(24'h00ffff, 24'h123456, 1'b0));
      send_pixel(pixel(24'hffffff, 24'h000000, 1'b0));
      send_pixel(pixel(24'hffffff, 24'h000000, 1'b1));
      send_pixel(pixel(24'h808080, 24'h000000, 1'b0));
      configure(LEN_W'(1048575), 1'b0);
      send_pixel(pixel(24'hffffff, 24'h000000, 1'b1));
      send_pixel(pixel(24'hfefefe, 24'h000000, 1'b0));
      send_pixel(pixel(24'h010101, 24'h010101, 1'b0));

      pix = pixel(24'h000000, 24'hffffff, 1'b0);
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               src_idle_pct  = 29;
               sink_idle_pct = 53;
            end
            1: begin
               src_idle_pct  = 53;
               sink_idle_pct = 29;
            end
            default: begin
               src_idle_pct  = 0;
               sink_idle_pct = 0;
            end
         endcase
         case (seg)
            0: configure(LEN_W'($urandom_range(1, 16)), 1'b0);
            1: configure(LEN_W'($urandom_range(17, 64)), 1'b0);
            2: configure('0, 1'b0);
            3: configure(LEN_W'($urandom_range(2, 40)), 1'b1);
            4: configure(LEN_W'(1048575), 1'b0);
            default: configure(LEN_W'($urandom_range(3, 12)), 1'b0);
         endcase
         for (int i = 0; i < SEG_ITEMS; i++) begin
            if ($urandom_range(199) == 0) settle();
            pix = next_pixel(pix);
            if (i == 0) pix.start_of_page = 1'b1;
            send_pixel(pix);
         end
      end

      settle();
      while (runs.expected_runs.size() != 0) begin
         runs.note_mismatch({"missing run word: ", runs.run_text(runs.expected_runs.pop_front())});
      end
      if (runs.mismatch_count == 0) begin
         $display("foreground_palette_run_length_encoder_core test passed");
      end else begin
         $display("foreground_palette_run_length_encoder_core test failed");
      end
      $finish;
   end
endmodule
